/* rtl/pcls_pkg.sv */
`timescale 1ns / 1ps

package pcls_pkg;

    // defaults for the top level parameters
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_DELAY_BITS   = 20;

    // fixed widths of the item fields
    localparam int REQ_W   = 2;
    localparam int CH_W    = 8;
    localparam int DS_W    = 20;
    localparam int COUNT_W = 32;

    // request kinds; the unused code behaves as a read
    localparam logic [REQ_W-1:0] REQ_MADE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EATEN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_OUT
    } t_state_e;

endpackage

/* rtl/pcls_req_if.sv */
`timescale 1ns / 1ps

interface pcls_req_if;
    import pcls_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [CH_W-1:0]  channel;
    logic [DS_W-1:0]  delay_sample;

    modport source (output valid, req_type, channel, delay_sample, input ready);
    modport sink   (input valid, req_type, channel, delay_sample, output ready);
endinterface

/* rtl/pcls_res_if.sv */
`timescale 1ns / 1ps

interface pcls_res_if;
    import pcls_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    entry_channel;
    logic [COUNT_W-1:0] made_count;
    logic [COUNT_W-1:0] eaten_count;
    logic [DS_W-1:0]    min_delay;
    logic [DS_W-1:0]    max_delay;
    logic [DS_W-1:0]    avg_delay;
    logic               has_sample;
    logic               count_mismatch;
    logic               index_error;

    modport source (output valid, entry_channel, made_count, eaten_count, min_delay,
                     max_delay, avg_delay, has_sample, count_mismatch, index_error,
                     input ready);
    modport sink   (input valid, entry_channel, made_count, eaten_count, min_delay,
                     max_delay, avg_delay, has_sample, count_mismatch, index_error,
                     output ready);
endinterface

/* rtl/per_channel_latency_stats_table.sv */
`timescale 1ns / 1ps
// Per-channel latency statistics table.
// i_req carries events (req_type, channel, delay_sample); o_res returns one item
// per event: the channel's entry after the event, the truncated average delay
// and the has-sample, mismatch and index-error flags. Both channels move an item
// when valid and ready are high at a rising edge.
// The entries live in one synchronous memory of NUM_CHANNELS words. An event is
// taken only in the idle state; the entry is read on the accepting edge,
// updated and written back in the next cycle, then, for an entry with samples,
// the average is formed by a restoring divider that retires one quotient bit
// per cycle. An out-of-range channel goes straight to the output state, an entry
// without samples passes through the read state only, and an entry with samples
// also passes through the divider. A new event is taken only after the result of
// the last one has been loaded into the output register.
// Output items sit in an output register; the next event is taken while a result
// waits there, and the block stalls only when a second result is ready before
// the first is taken.
// Reset (synchronous, active low) clears one valid bit per entry, so every entry
// reads as zero until it is first written; o_res.valid clears at the reset edge.
module per_channel_latency_stats_table #(
    parameter int NUM_CHANNELS = pcls_pkg::DEF_NUM_CHANNELS,
    parameter int DELAY_BITS   = pcls_pkg::DEF_DELAY_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcls_req_if.sink    i_req,
    pcls_res_if.source  o_res
);
    import pcls_pkg::*;

    localparam int IDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TOTAL_BITS = COUNT_W + DELAY_BITS;
    localparam int SUM_W      = TOTAL_BITS + 1;
    localparam int CNT_W      = $clog2(TOTAL_BITS);

    typedef struct packed {
        logic [COUNT_W-1:0]    made;
        logic [COUNT_W-1:0]    eaten;
        logic [DELAY_BITS-1:0] min;
        logic [DELAY_BITS-1:0] max;
        logic [TOTAL_BITS-1:0] total;
        logic                  seen;
    } t_entry;

    t_entry r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;

    t_state_e r_state, n_state;

    logic                  w_accept;
    logic                  w_in_range;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [31:0]           w_d_ext;
    logic                  w_out_load;

    logic [REQ_W-1:0]      r_req;
    logic [CH_W-1:0]       r_ch;
    logic [DELAY_BITS-1:0] r_d;

    t_entry                r_rd_data;
    logic                  r_rd_valid;
    t_entry                w_cur;
    t_entry                n_entry;
    logic [SUM_W-1:0]      w_sum;

    logic [COUNT_W-1:0]    r_res_made;
    logic [COUNT_W-1:0]    r_res_eaten;
    logic [DELAY_BITS-1:0] r_res_min;
    logic [DELAY_BITS-1:0] r_res_max;
    logic                  r_res_seen;
    logic                  r_res_mismatch;
    logic                  r_res_err;
    logic                  r_use_avg;

    logic [TOTAL_BITS-1:0] r_dvd;
    logic [COUNT_W-1:0]    r_div;
    logic [COUNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic [COUNT_W:0]      w_trial;
    logic                  w_qbit;
    logic [DELAY_BITS-1:0] w_avg_clamp;
    logic [31:0]           w_avg_ext;

    logic                  r_out_valid;
    logic [CH_W-1:0]       r_out_ch;
    logic [COUNT_W-1:0]    r_out_made;
    logic [COUNT_W-1:0]    r_out_eaten;
    logic [DS_W-1:0]       r_out_min;
    logic [DS_W-1:0]       r_out_max;
    logic [DS_W-1:0]       r_out_avg;
    logic                  r_out_seen;
    logic                  r_out_mismatch;
    logic                  r_out_err;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_in_range = {1'b0, i_req.channel} < (CH_W + 1)'(NUM_CHANNELS);
    assign w_rd_addr  = i_req.channel[IDX_W-1:0];
    assign w_d_ext    = 32'(i_req.delay_sample);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = w_in_range ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                n_state = n_entry.seen ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(TOTAL_BITS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entry update; an entry never written reads as zero
    always_comb begin
        w_cur   = r_rd_valid ? r_rd_data : '0;
        n_entry = w_cur;
        w_sum   = {1'b0, w_cur.total} + SUM_W'(r_d);
        case (r_req)
            REQ_MADE: begin
                if (w_cur.made != '1) begin
                    n_entry.made = w_cur.made + COUNT_W'(1);
                end
            end
            REQ_EATEN: begin
                if (w_cur.eaten != '1) begin
                    n_entry.eaten = w_cur.eaten + COUNT_W'(1);
                end
                if (!w_cur.seen) begin
                    n_entry.seen  = 1'b1;
                    n_entry.min   = r_d;
                    n_entry.max   = r_d;
                    n_entry.total = TOTAL_BITS'(r_d);
                end else begin
                    if (r_d < w_cur.min) begin
                        n_entry.min = r_d;
                    end
                    if (r_d > w_cur.max) begin
                        n_entry.max = r_d;
                    end
                    // saturate the total on carry out
                    n_entry.total = w_sum[TOTAL_BITS] ? '1 : w_sum[TOTAL_BITS-1:0];
                end
            end
            default: begin
                n_entry = w_cur;
            end
        endcase
    end

    // memory: read on accept, write back in S_READ
    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_range) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (r_state == S_READ) begin
            r_mem[r_ch[IDX_W-1:0]] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (w_accept && w_in_range) begin
                r_rd_valid <= r_valid[w_rd_addr];
            end
            if (r_state == S_READ) begin
                r_valid[r_ch[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // restoring divider step
    assign w_trial = {r_rem, r_dvd[TOTAL_BITS-1]};
    assign w_qbit  = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_req <= i_req.req_type;
                    r_ch  <= i_req.channel;
                    r_d   <= w_d_ext[DELAY_BITS-1:0];
                    if (!w_in_range) begin
                        r_res_made     <= '0;
                        r_res_eaten    <= '0;
                        r_res_min      <= '0;
                        r_res_max      <= '0;
                        r_res_seen     <= 1'b0;
                        r_res_mismatch <= 1'b0;
                        r_res_err      <= 1'b1;
                        r_use_avg      <= 1'b0;
                    end
                end
            end
            S_READ: begin
                r_res_made     <= n_entry.made;
                r_res_eaten    <= n_entry.eaten;
                r_res_min      <= n_entry.min;
                r_res_max      <= n_entry.max;
                r_res_seen     <= n_entry.seen;
                r_res_mismatch <= n_entry.made != n_entry.eaten;
                r_res_err      <= 1'b0;
                r_use_avg      <= n_entry.seen;
                r_dvd          <= n_entry.total;
                r_div          <= n_entry.eaten;
                r_rem          <= '0;
                r_cnt          <= '0;
            end
            S_DIV: begin
                r_rem <= w_qbit ? COUNT_W'(w_trial - {1'b0, r_div}) : w_trial[COUNT_W-1:0];
                r_dvd <= {r_dvd[TOTAL_BITS-2:0], w_qbit};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // clamp the quotient to the delay range
    assign w_avg_clamp = (r_dvd[TOTAL_BITS-1:DELAY_BITS] != '0) ? '1 : r_dvd[DELAY_BITS-1:0];
    assign w_avg_ext   = 32'(w_avg_clamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_ch       <= r_ch;
            r_out_made     <= r_res_made;
            r_out_eaten    <= r_res_eaten;
            r_out_min      <= DS_W'(32'(r_res_min));
            r_out_max      <= DS_W'(32'(r_res_max));
            r_out_avg      <= r_use_avg ? w_avg_ext[DS_W-1:0] : '0;
            r_out_seen     <= r_res_seen;
            r_out_mismatch <= r_res_mismatch;
            r_out_err      <= r_res_err;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.entry_channel  = r_out_ch;
    assign o_res.made_count     = r_out_made;
    assign o_res.eaten_count    = r_out_eaten;
    assign o_res.min_delay      = r_out_min;
    assign o_res.max_delay      = r_out_max;
    assign o_res.avg_delay      = r_out_avg;
    assign o_res.has_sample     = r_out_seen;
    assign o_res.count_mismatch = r_out_mismatch;
    assign o_res.index_error    = r_out_err;

endmodule

/* rtl/pcls_checker.sv */
`timescale 1ns / 1ps

module pcls_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [pcls_pkg::CH_W-1:0]    i_entry_channel,
    input logic [pcls_pkg::COUNT_W-1:0] i_made_count,
    input logic [pcls_pkg::COUNT_W-1:0] i_eaten_count,
    input logic [pcls_pkg::DS_W-1:0]    i_min_delay,
    input logic [pcls_pkg::DS_W-1:0]    i_max_delay,
    input logic [pcls_pkg::DS_W-1:0]    i_avg_delay,
    input logic                         i_has_sample,
    input logic                         i_count_mismatch,
    input logic                         i_index_error
);
    import pcls_pkg::*;

    // hold a stalled item
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_entry_channel)
            && $stable(i_made_count) && $stable(i_avg_delay))
        else $error("stalled result item changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_index_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_index_error |-> i_made_count == '0 && i_eaten_count == '0
            && !i_has_sample && !i_count_mismatch && i_avg_delay == '0)
        else $error("out-of-range item carries entry data");

    a_sample_vs_eaten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_index_error |-> i_has_sample == (i_eaten_count != '0)
            && (i_has_sample || (i_min_delay == '0 && i_max_delay == '0
            && i_avg_delay == '0)))
        else $error("has_sample disagrees with eaten count or delays");

endmodule

bind per_channel_latency_stats_table pcls_checker u_pcls_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_entry_channel  (o_res.entry_channel),
    .i_made_count     (o_res.made_count),
    .i_eaten_count    (o_res.eaten_count),
    .i_min_delay      (o_res.min_delay),
    .i_max_delay      (o_res.max_delay),
    .i_avg_delay      (o_res.avg_delay),
    .i_has_sample     (o_res.has_sample),
    .i_count_mismatch (o_res.count_mismatch),
    .i_index_error    (o_res.index_error)
);
